// File: rtl/lds_pkg.sv
// types, constants and decode functions for the segment scanner
// no dependencies; used by every other file of the block

package lds_pkg;

  localparam int unsigned ValueW   = 14;
  localparam int unsigned RailW    = 9;
  localparam int unsigned HoldW    = 2;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned SlotCount = 16;
  localparam int unsigned SlotW    = 4;

  localparam logic [ValueW-1:0] LimitAll   = 14'd2000;
  localparam logic [10:0]       LimitSmall = 11'd200;

  localparam logic [RailW-1:0] LeadPattern = 9'h09E;
  localparam logic [HoldW-1:0] HoldLead    = 2'd3;
  localparam logic [HoldW-1:0] HoldSeg     = 2'd1;

  localparam logic [7:0] FirstCols [8] = '{
    8'h87, 8'h8B, 8'h8D, 8'h47, 8'h4B, 8'h4D, 8'h4E, 8'h8E
  };
  localparam logic [7:0] SecondCols [8] = '{
    8'h27, 8'h2B, 8'h2D, 8'h17, 8'h1B, 8'h1D, 8'h1E, 8'h2E
  };

  typedef struct packed {
    logic              lead;
    logic              point;
    logic [DigitW-1:0] d1;
    logic [DigitW-1:0] d2;
  } cmd_t;

  // lit segments, bit6 = a ... bit0 = g
  function automatic logic [6:0] digit_segs(input logic [DigitW-1:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'h7E;
      4'd1:    s = 7'h30;
      4'd2:    s = 7'h6D;
      4'd3:    s = 7'h79;
      4'd4:    s = 7'h33;
      4'd5:    s = 7'h5B;
      4'd6:    s = 7'h5F;
      4'd7:    s = 7'h70;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h7B;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // column pattern to rail levels, rail 1 always high
  function automatic logic [RailW-1:0] cols_to_rails(input logic [7:0] c);
    return {c[6], c[7], c[4], c[5], c[0], c[1], c[2], c[3], 1'b1};
  endfunction

  // slot 0 leading one, 1..8 first digit a..g and point, 9..15 second digit a..g
  function automatic logic [RailW-1:0] slot_rails(input logic [SlotW-1:0] slot);
    logic [RailW-1:0] p;
    if (slot == '0) begin
      p = LeadPattern;
    end else if (slot <= 4'd8) begin
      p = cols_to_rails(FirstCols[3'(slot - 4'd1)]);
    end else begin
      p = cols_to_rails(SecondCols[3'(slot - 4'd9)]);
    end
    return p;
  endfunction

endpackage

// File: rtl/lds_if.sv
// valid/ready channel interfaces for refresh requests and rail patterns
// depends on lds_pkg for field widths

interface lds_in_if;
  logic                           valid;
  logic                           ready;
  logic [lds_pkg::ValueW-1:0]     value_tenths;

  modport source (output valid, output value_tenths, input ready);
  modport sink   (input valid, input value_tenths, output ready);
endinterface

interface lds_out_if;
  logic                           valid;
  logic                           ready;
  logic [lds_pkg::RailW-1:0]      rail_pattern;
  logic [lds_pkg::HoldW-1:0]      hold_ms;
  logic                           last;

  modport source (output valid, output rail_pattern, output hold_ms, output last,
                  input ready);
  modport sink   (input valid, input rail_pattern, input hold_ms, input last,
                  output ready);
endinterface

// File: rtl/lds_front.sv
// front end: takes refresh requests, splits the value into digits, drops
// values of 2000 tenths or more; depends on lds_pkg and lds_if

module lds_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  lds_in_if.sink        in_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output lds_pkg::cmd_t cmd_o
);
  import lds_pkg::*;

  logic        valid_q, valid_d;
  logic [10:0] v_q, v_d;
  logic [7:0]  q10_q, q10_d;

  logic [26:0] prod1;
  logic [15:0] prod2;
  logic [4:0]  q100;
  logic [7:0]  q10_rem;
  logic [10:0] v_rem;
  logic        is_low;
  logic        accept;
  logic [4:0]  q100_mod;

  assign in_i.ready = !valid_q || cmd_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  // divide by ten through a reciprocal, exact below 2048
  assign prod1 = 27'(in_i.value_tenths[10:0]) * 27'd52429;

  always_comb begin
    valid_d = valid_q;
    v_d     = v_q;
    q10_d   = q10_q;
    if (accept) begin
      valid_d = in_i.value_tenths < LimitAll;
      v_d     = in_i.value_tenths[10:0];
      q10_d   = prod1[26:19];
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    q10_q <= q10_d;
  end

  assign prod2    = 16'(q10_q) * 16'd205;
  assign q100     = prod2[15:11];
  assign q10_rem  = q10_q - 8'(q100) * 8'd10;
  assign v_rem    = v_q - 11'(q10_q) * 11'd10;
  assign is_low   = v_q < LimitSmall;
  assign q100_mod = (q100 >= 5'd10) ? q100 - 5'd10 : q100;

  always_comb begin
    if (is_low) begin
      cmd_o.lead  = q10_q >= 8'd10;
      cmd_o.point = 1'b1;
      cmd_o.d1    = q10_rem[3:0];
      cmd_o.d2    = v_rem[3:0];
    end else begin
      cmd_o.lead  = q100 >= 5'd10;
      cmd_o.point = 1'b0;
      cmd_o.d1    = q100_mod[3:0];
      cmd_o.d2    = q10_rem[3:0];
    end
  end

  assign cmd_valid_o = valid_q;

endmodule

// File: rtl/lds_fifo.sv
// short command queue between front and back end
// depends on lds_pkg for the command type

module lds_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  lds_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output lds_pkg::cmd_t rd_data_o
);
  import lds_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign wr_ready_o = cnt_q != CntW'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// File: rtl/lds_back.sv
// back end: expands one command into rail patterns, one per cycle while out_o is ready
// depends on lds_pkg and lds_if

module lds_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  lds_pkg::cmd_t cmd_i,
  lds_out_if.source     out_o
);
  import lds_pkg::*;

  logic                 busy_q, busy_d;
  logic [SlotCount-1:0] mask_q, mask_d;
  logic                 oval_q, oval_d;
  logic [RailW-1:0]     rail_q, rail_d;
  logic [HoldW-1:0]     hold_q, hold_d;
  logic                 last_q, last_d;

  logic [SlotCount-1:0] new_mask;
  logic [SlotCount-1:0] rest;
  logic [SlotW-1:0]     sel;
  logic [6:0]           segs1, segs2;
  logic                 fire;

  assign cmd_ready_o = !busy_q;
  assign fire        = busy_q && (!oval_q || out_o.ready);
  assign segs1       = digit_segs(cmd_i.d1);
  assign segs2       = digit_segs(cmd_i.d2);
  assign rest        = mask_q & (mask_q - 1'b1);

  always_comb begin
    new_mask    = '0;
    new_mask[0] = cmd_i.lead;
    for (int s = 0; s < 7; s++) begin
      new_mask[1 + s] = segs1[6 - s];
      new_mask[9 + s] = segs2[6 - s];
    end
    new_mask[8] = cmd_i.point;
  end

  // lowest pending slot
  always_comb begin
    sel = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = SlotW'(i);
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    mask_d = mask_q;
    oval_d = oval_q;
    rail_d = rail_q;
    hold_d = hold_q;
    last_d = last_q;
    if (!busy_q && cmd_valid_i) begin
      busy_d = 1'b1;
      mask_d = new_mask;
    end
    if (out_o.ready) begin
      oval_d = 1'b0;
    end
    if (fire) begin
      oval_d = 1'b1;
      rail_d = slot_rails(sel);
      hold_d = (sel == '0) ? HoldLead : HoldSeg;
      last_d = rest == '0;
      mask_d = rest;
      busy_d = rest != '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mask_q <= '0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      mask_q <= mask_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rail_q <= rail_d;
    hold_q <= hold_d;
    last_q <= last_d;
  end

  assign out_o.valid        = oval_q;
  assign out_o.rail_pattern = rail_q;
  assign out_o.hold_ms      = hold_q;
  assign out_o.last         = last_q;

endmodule

// File: rtl/led_display_segment_scanner.sv
// segment scanner top: front end, command queue, back end
// a request passes the front register, the command queue, the back-end command load
// and the output register before its first pattern shows; a refresh occupies the
// back end for one command load, then one pattern per cycle while out_o is ready
// values of 2000 tenths or more are dropped in the front end without output
// reset: asynchronous active low, clears queue and all valid state

module led_display_segment_scanner #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lds_in_if.sink    in_i,
  lds_out_if.source out_o
);
  import lds_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  lds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  lds_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cmd_valid),
    .wr_ready_o (cmd_ready),
    .wr_data_i  (cmd),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_cmd)
  );

  lds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_o       (out_o)
  );

endmodule

// File: verif/lds_scan_monitor.sv
// monitor for the segment scanner: watches both channels, predicts rail patterns
// for every accepted refresh and compares each pattern transfer in order
// depends on lds_pkg and the channel interfaces in lds_if

`timescale 1ns / 1ps

module lds_scan_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  lds_in_if           in_mon,
  lds_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  import lds_pkg::*;

  typedef struct packed {
    logic [RailW-1:0] rail;
    logic [HoldW-1:0] hold;
    logic             last;
  } drive_t;

  localparam logic [RailW-1:0] LeadRails = 9'h09E;
  localparam logic [HoldW-1:0] LeadHold  = 2'd3;
  localparam logic [HoldW-1:0] SegHold   = 2'd1;

  // bit6 = a ... bit0 = g
  localparam logic [6:0] SegLut [10] = '{
    7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B
  };
  localparam logic [7:0] LeftCols [8] = '{
    8'h87, 8'h8B, 8'h8D, 8'h47, 8'h4B, 8'h4D, 8'h4E, 8'h8E
  };
  localparam logic [7:0] RightCols [8] = '{
    8'h27, 8'h2B, 8'h2D, 8'h17, 8'h1B, 8'h1D, 8'h1E, 8'h2E
  };
  localparam int unsigned RailOfCol [8] = '{8, 9, 6, 7, 2, 3, 4, 5};

  drive_t      pattern_q [$];
  int unsigned fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = pattern_q.size();

  function automatic logic [RailW-1:0] rails_of(input logic [7:0] cols);
    logic [RailW-1:0] p;
    p = 9'h001;
    for (int c = 0; c < 8; c++) begin
      if (cols[7-c]) p[RailOfCol[c]-1] = 1'b1;
    end
    return p;
  endfunction

  task automatic queue_refresh_patterns(input logic [ValueW-1:0] value);
    int unsigned v;
    int unsigned d1;
    int unsigned d2;
    bit          lead;
    bit          point;
    logic [6:0]  segs;
    drive_t      batch [$];
    v = value;
    if (v >= 2000) return;
    if (v < 200) begin
      lead  = (v >= 100);
      d1    = (v / 10) % 10;
      d2    = v % 10;
      point = 1'b1;
    end else begin
      lead  = (v >= 1000);
      d1    = (v / 100) % 10;
      d2    = (v / 10) % 10;
      point = 1'b0;
    end
    if (lead) batch.push_back('{LeadRails, LeadHold, 1'b0});
    segs = SegLut[d1];
    for (int s = 0; s < 7; s++) begin
      if (segs[6-s]) batch.push_back('{rails_of(LeftCols[s]), SegHold, 1'b0});
    end
    if (point) batch.push_back('{rails_of(LeftCols[7]), SegHold, 1'b0});
    segs = SegLut[d2];
    for (int s = 0; s < 7; s++) begin
      if (segs[6-s]) batch.push_back('{rails_of(RightCols[s]), SegHold, 1'b0});
    end
    batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) pattern_q.push_back(batch[i]);
  endtask

  initial fail_count = 0;

  always @(posedge clk_i) begin
    drive_t want;
    if (rst_ni) begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (pattern_q.size() == 0) begin
          $error("unexpected pattern transfer: rail_pattern %h", out_mon.rail_pattern);
          fail_count++;
        end else begin
          want = pattern_q.pop_front();
          if (out_mon.rail_pattern !== want.rail) begin
            $error("rail_pattern mismatch: expected %h, actual %h",
                   want.rail, out_mon.rail_pattern);
            fail_count++;
          end
          if (out_mon.hold_ms !== want.hold) begin
            $error("hold_ms mismatch: expected %0d, actual %0d", want.hold, out_mon.hold_ms);
            fail_count++;
          end
          if (out_mon.last !== want.last) begin
            $error("last mismatch: expected %b, actual %b", want.last, out_mon.last);
            fail_count++;
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        queue_refresh_patterns(in_mon.value_tenths);
      end
    end
  end

endmodule

// File: verif/led_display_segment_scanner_tb.sv
// testbench top for the segment scanner: clock, reset, refresh requests and
// pattern back-pressure; checking is done in lds_scan_monitor
// depends on lds_pkg, lds_if, the scanner rtl and lds_scan_monitor

`timescale 1ns / 1ps

module led_display_segment_scanner_tb;

  import lds_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned rx_count;
  int unsigned tx_index;

  lds_in_if  in_ch ();
  lds_out_if out_ch ();

  led_display_segment_scanner uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  lds_scan_monitor monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  task automatic send_refresh(input logic [ValueW-1:0] value);
    int unsigned gap;
    gap = ((tx_index % 64) >= 48) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.value_tenths <= value;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    tx_index++;
  endtask

  function automatic logic [ValueW-1:0] random_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return ValueW'($urandom_range(0, 199));
    if (r < 85) return ValueW'($urandom_range(200, 1999));
    return ValueW'($urandom_range(2000, 16383));
  endfunction

  task automatic drain_patterns();
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // pattern receiver with random stalls and one long hold-off
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    rx_count = 0;
    @(posedge clk_i);
    wait (rst_ni === 1'b1);
    forever begin
      stall = ((rx_count % 200) >= 150) ? 0 : $urandom_range(0, 8);
      if (rx_count == 1000) stall = 400;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      rx_count++;
    end
  end

  initial begin
    logic [ValueW-1:0] directed [$];
    logic [ValueW-1:0] v;
    int unsigned       shown;
    directed = '{14'd0, 14'd1, 14'd9, 14'd10, 14'd19, 14'd99, 14'd100, 14'd101,
                 14'd118, 14'd199, 14'd200, 14'd201, 14'd999, 14'd1000, 14'd1234,
                 14'd1567, 14'd1890, 14'd1999, 14'd2000, 14'd2001, 14'd8192,
                 14'd16383, 14'd5461, 14'd10922, 14'd150};
    tx_index = 0;
    rst_ni             <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.value_tenths <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_refresh(directed[i]);
    in_ch.valid <= 1'b0;
    drain_patterns();

    shown = 0;
    while (shown < 295) begin
      if (shown == 180) begin
        in_ch.valid <= 1'b0;
        drain_patterns();
      end
      v = random_value();
      send_refresh(v);
      if (v < 2000) shown++;
    end
    in_ch.valid <= 1'b0;

    drain_patterns();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
